### rtl/sdfcf_pkg.sv
// ----------------------------------------------------------------------------
// sdfcf_pkg
// shared widths, register indexes, operator codes, sequencer types and
// fixed-point constants for the sdf combine fold unit
// ----------------------------------------------------------------------------
`default_nettype none

package sdfcf_pkg;

    localparam int DIST_W     = 32;
    localparam int K_W        = 31;
    localparam int MODE_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;

    // shared multiplier operand and product widths
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // width of an unclipped combine result
    localparam int D_W = 36;

    localparam logic [CFG_IDX_W-1:0] REG_COMBINE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_RECIP  = 2'd2;

    localparam logic [MODE_W-1:0] MODE_UNION          = 4'd0;
    localparam logic [MODE_W-1:0] MODE_SMOOTH_UNION   = 4'd1;
    localparam logic [MODE_W-1:0] MODE_CHAMFER_UNION  = 4'd2;
    localparam logic [MODE_W-1:0] MODE_INTER          = 4'd3;
    localparam logic [MODE_W-1:0] MODE_SMOOTH_INTER   = 4'd4;
    localparam logic [MODE_W-1:0] MODE_CHAMFER_INTER  = 4'd5;
    localparam logic [MODE_W-1:0] MODE_DIFF           = 4'd6;
    localparam logic [MODE_W-1:0] MODE_SMOOTH_DIFF    = 4'd7;
    localparam logic [MODE_W-1:0] MODE_CHAMFER_DIFF   = 4'd8;

    localparam logic [K_W-1:0] BLEND_RESET = 31'd65536;

    // sqrt(0.5) in Q4.30
    localparam logic signed [MUL_W-1:0] SQRT_HALF_Q30 = 34'sd759250125;
    localparam int                      CHAMFER_SHIFT = 30;

    // floor(y / 3) = (y * DIV3_MULT) >> DIV3_SHIFT for y < 2^31
    localparam logic signed [MUL_W-1:0] DIV3_MULT  = 34'sd1431655766;
    localparam int                      DIV3_SHIFT = 32;

    localparam logic signed [D_W-1:0] ACC_MAX = 36'sd2147483647;
    localparam logic signed [D_W-1:0] ACC_MIN = -36'sd2147483648;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PREP  = 6'b000010,
        S_MUL   = 6'b000100,
        S_STEP  = 6'b001000,
        S_WRITE = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    typedef enum logic [9:0] {
        ST_SU_H   = 10'b0000000001,
        ST_SU_H2  = 10'b0000000010,
        ST_SU_H3  = 10'b0000000100,
        ST_SU_X   = 10'b0000001000,
        ST_SU_DIV = 10'b0000010000,
        ST_SI_H   = 10'b0000100000,
        ST_SI_UH  = 10'b0001000000,
        ST_SI_G   = 10'b0010000000,
        ST_SI_KG  = 10'b0100000000,
        ST_CH     = 10'b1000000000
    } step_t;

endpackage

`default_nettype wire

### rtl/sdfcf_mul_unit.sv
// ----------------------------------------------------------------------------
// sdfcf_mul_unit
// shared signed multiplier with operand registers and a registered product,
// the product register is fed from the operand registers
// ----------------------------------------------------------------------------
`default_nettype none

module sdfcf_mul_unit (
    input  logic                                  clk,
    input  logic                                  load,
    input  logic signed [sdfcf_pkg::MUL_W-1:0]    a_in,
    input  logic signed [sdfcf_pkg::MUL_W-1:0]    b_in,
    output logic signed [sdfcf_pkg::PROD_W-1:0]   product
);

    logic signed [sdfcf_pkg::MUL_W-1:0]  op_a_reg;
    logic signed [sdfcf_pkg::MUL_W-1:0]  op_b_reg;
    logic signed [sdfcf_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_a_reg <= a_in;
            op_b_reg <= b_in;
        end
        prod_reg <= op_a_reg * op_b_reg;
    end

    assign product = prod_reg;

endmodule

`default_nettype wire

### rtl/sdf_csg_combine_fold_unit.sv
// ----------------------------------------------------------------------------
// sdf_csg_combine_fold_unit
// Flow: a run seed only loads the accumulator; a simple min/max step skips the multiplier,
//   a chamfer step uses one product, smooth intersection/difference a chain of products,
//   smooth union too unless the inputs are a blend width or more apart; a last item then emits.
// Throughput: one item at a time, bound by the single shared 34x34 multiplier;
//   in_stall is high from accept until done.
// Reset: async active low, clears the run, accumulator and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module sdf_csg_combine_fold_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     cfg_write,
    input  logic [sdfcf_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [sdfcf_pkg::CFG_DATA_W-1:0]         cfg_data,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic signed [sdfcf_pkg::DIST_W-1:0]      child_distance,
    input  logic                                     last_child,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic signed [sdfcf_pkg::DIST_W-1:0]      combined_distance,
    output logic                                     saturated
);

    localparam int H_W     = FRAC_BITS + 1;
    localparam int ONE_INT = 1 << FRAC_BITS;
    localparam logic [H_W-1:0] ONE_H  = H_W'(ONE_INT);
    localparam logic [H_W-1:0] HALF_H = H_W'(ONE_INT / 2);
    localparam logic signed [sdfcf_pkg::PROD_W-1:0] ONE_P  = sdfcf_pkg::PROD_W'(ONE_INT);
    localparam logic signed [sdfcf_pkg::PROD_W-1:0] HALF_P = sdfcf_pkg::PROD_W'(ONE_INT / 2);

    // configuration
    logic [sdfcf_pkg::MODE_W-1:0] combine_mode_reg;
    logic [sdfcf_pkg::K_W-1:0]    blend_width_reg;
    logic [sdfcf_pkg::K_W-1:0]    blend_recip_reg;

    // control
    sdfcf_pkg::state_t state_reg, state_next;
    sdfcf_pkg::step_t  step_reg, step_next;
    logic run_open_reg, run_open_next;
    logic sat_seen_reg, sat_seen_next;
    logic signed [sdfcf_pkg::DIST_W-1:0] acc_reg, acc_next;
    logic out_valid_reg, out_valid_next;
    logic out_load;

    // working registers
    logic signed [sdfcf_pkg::DIST_W-1:0] a_reg, a_next;
    logic                                last_reg, last_next;
    logic signed [sdfcf_pkg::MUL_W-1:0]  u_reg, u_next;
    logic signed [sdfcf_pkg::MUL_W-1:0]  mnmx_reg, mnmx_next;
    logic [H_W-1:0]                      h_reg, h_next;
    logic signed [sdfcf_pkg::D_W-1:0]    res_reg, res_next;

    logic signed [sdfcf_pkg::DIST_W-1:0] combined_reg;
    logic                                saturated_reg;

    // multiplier
    logic                                 mul_load;
    logic signed [sdfcf_pkg::MUL_W-1:0]   mul_a;
    logic signed [sdfcf_pkg::MUL_W-1:0]   mul_b;
    logic signed [sdfcf_pkg::PROD_W-1:0]  prod;
    logic signed [sdfcf_pkg::PROD_W-1:0]  prod_f;
    logic signed [sdfcf_pkg::PROD_W-1:0]  prod_f1;
    logic signed [sdfcf_pkg::PROD_W-1:0]  prod_div;
    logic signed [sdfcf_pkg::PROD_W-1:0]  prod_ch;
    logic signed [sdfcf_pkg::PROD_W-1:0]  si_t;

    // operator decode
    logic op_max, op_su, op_si, op_ch, is_diff, is_union;

    // setup values
    logic signed [sdfcf_pkg::MUL_W-1:0] a_ext, a_eff, b_ext, k_ext, r_ext;
    logic signed [sdfcf_pkg::MUL_W-1:0] u, d_abs, kd, uc, s, mn, mx;
    logic                               d_lt_k;
    logic [H_W-1:0]                     hz;

    // step values
    logic [H_W-1:0]                     h_clip;
    logic [H_W-1:0]                     hs_clip;
    logic signed [sdfcf_pkg::D_W-1:0]   mnmx_d;
    logic signed [sdfcf_pkg::D_W-1:0]   cand;
    logic signed [sdfcf_pkg::D_W-1:0]   term;

    sdfcf_mul_unit u_mul (
        .clk     (clk),
        .load    (mul_load),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .product (prod)
    );

    assign prod_f   = prod >>> FRAC_BITS;
    assign prod_f1  = prod >>> (FRAC_BITS + 1);
    assign prod_div = prod >>> sdfcf_pkg::DIV3_SHIFT;
    assign prod_ch  = prod >>> sdfcf_pkg::CHAMFER_SHIFT;
    assign si_t     = prod_f1 + HALF_P;

    always_comb
    begin
        op_max   = 1'b0;
        op_su    = 1'b0;
        op_si    = 1'b0;
        op_ch    = 1'b0;
        is_diff  = 1'b0;
        is_union = 1'b0;
        case (combine_mode_reg)
            sdfcf_pkg::MODE_SMOOTH_UNION:
            begin
                op_su    = 1'b1;
                is_union = 1'b1;
            end
            sdfcf_pkg::MODE_CHAMFER_UNION:
            begin
                op_ch    = 1'b1;
                is_union = 1'b1;
            end
            sdfcf_pkg::MODE_INTER:         op_max = 1'b1;
            sdfcf_pkg::MODE_SMOOTH_INTER:  op_si  = 1'b1;
            sdfcf_pkg::MODE_CHAMFER_INTER: op_ch  = 1'b1;
            sdfcf_pkg::MODE_DIFF:
            begin
                op_max  = 1'b1;
                is_diff = 1'b1;
            end
            sdfcf_pkg::MODE_SMOOTH_DIFF:
            begin
                op_si   = 1'b1;
                is_diff = 1'b1;
            end
            sdfcf_pkg::MODE_CHAMFER_DIFF:
            begin
                op_ch   = 1'b1;
                is_diff = 1'b1;
            end
            default:
            begin
                is_union = 1'b1;
            end
        endcase
    end

    // setup arithmetic on the new distance and the accumulator
    always_comb
    begin
        a_ext  = sdfcf_pkg::MUL_W'(a_reg);
        a_eff  = is_diff ? -a_ext : a_ext;
        b_ext  = sdfcf_pkg::MUL_W'(acc_reg);
        k_ext  = sdfcf_pkg::MUL_W'(blend_width_reg);
        r_ext  = sdfcf_pkg::MUL_W'(blend_recip_reg);
        u      = a_eff - b_ext;
        d_abs  = u[sdfcf_pkg::MUL_W-1] ? -u : u;
        d_lt_k = d_abs < k_ext;
        kd     = k_ext - d_abs;
        uc     = (u > k_ext) ? k_ext : ((u < -k_ext) ? -k_ext : u);
        s      = a_eff + b_ext + (is_union ? -k_ext : k_ext);
        mn     = (a_eff < b_ext) ? a_eff : b_ext;
        mx     = (a_eff > b_ext) ? a_eff : b_ext;
        hz     = (u > 0) ? ONE_H : ((u < 0) ? '0 : HALF_H);
    end

    // clamps and rescaling of the registered product
    always_comb
    begin
        h_clip  = (prod_f > ONE_P) ? ONE_H : prod_f[H_W-1:0];
        if (si_t < 0)
            hs_clip = '0;
        else if (si_t > ONE_P)
            hs_clip = ONE_H;
        else
            hs_clip = si_t[H_W-1:0];
        mnmx_d = sdfcf_pkg::D_W'(mnmx_reg);
        cand   = $signed(prod_ch[sdfcf_pkg::D_W-1:0]);
        term   = $signed(prod_div[sdfcf_pkg::D_W-1:0]);
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        run_open_next  = run_open_reg;
        sat_seen_next  = sat_seen_reg;
        acc_next       = acc_reg;
        a_next         = a_reg;
        last_next      = last_reg;
        u_next         = u_reg;
        mnmx_next      = mnmx_reg;
        h_next         = h_reg;
        res_next       = res_reg;
        mul_load       = 1'b0;
        mul_a          = '0;
        mul_b          = '0;
        out_load       = 1'b0;

        case (state_reg)
            sdfcf_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    if (!run_open_reg)
                    begin
                        acc_next      = child_distance;
                        sat_seen_next = 1'b0;
                        run_open_next = 1'b1;
                        if (last_child)
                            state_next = sdfcf_pkg::S_EMIT;
                    end
                    else
                    begin
                        a_next     = child_distance;
                        last_next  = last_child;
                        state_next = sdfcf_pkg::S_PREP;
                    end
                end
            end

            sdfcf_pkg::S_PREP:
            begin
                u_next = u;
                if (op_su)
                begin
                    mnmx_next = mn;
                    if (d_lt_k)
                    begin
                        mul_load   = 1'b1;
                        mul_a      = kd;
                        mul_b      = r_ext;
                        step_next  = sdfcf_pkg::ST_SU_H;
                        state_next = sdfcf_pkg::S_MUL;
                    end
                    else
                    begin
                        res_next   = sdfcf_pkg::D_W'(mn);
                        state_next = sdfcf_pkg::S_WRITE;
                    end
                end
                else if (op_si)
                begin
                    mul_load = 1'b1;
                    if (blend_width_reg == '0)
                    begin
                        h_next    = hz;
                        mul_a     = u;
                        mul_b     = sdfcf_pkg::MUL_W'(hz);
                        step_next = sdfcf_pkg::ST_SI_UH;
                    end
                    else
                    begin
                        mul_a     = uc;
                        mul_b     = r_ext;
                        step_next = sdfcf_pkg::ST_SI_H;
                    end
                    state_next = sdfcf_pkg::S_MUL;
                end
                else if (op_ch)
                begin
                    mnmx_next  = is_union ? mn : mx;
                    mul_load   = 1'b1;
                    mul_a      = s;
                    mul_b      = sdfcf_pkg::SQRT_HALF_Q30;
                    step_next  = sdfcf_pkg::ST_CH;
                    state_next = sdfcf_pkg::S_MUL;
                end
                else
                begin
                    res_next   = sdfcf_pkg::D_W'(op_max ? mx : mn);
                    state_next = sdfcf_pkg::S_WRITE;
                end
            end

            sdfcf_pkg::S_MUL:
            begin
                state_next = sdfcf_pkg::S_STEP;
            end

            sdfcf_pkg::S_STEP:
            begin
                state_next = sdfcf_pkg::S_MUL;
                case (step_reg)
                    sdfcf_pkg::ST_SU_H:
                    begin
                        h_next    = h_clip;
                        mul_load  = 1'b1;
                        mul_a     = sdfcf_pkg::MUL_W'(h_clip);
                        mul_b     = sdfcf_pkg::MUL_W'(h_clip);
                        step_next = sdfcf_pkg::ST_SU_H2;
                    end
                    sdfcf_pkg::ST_SU_H2:
                    begin
                        mul_load  = 1'b1;
                        mul_a     = sdfcf_pkg::MUL_W'(prod_f[H_W-1:0]);
                        mul_b     = sdfcf_pkg::MUL_W'(h_reg);
                        step_next = sdfcf_pkg::ST_SU_H3;
                    end
                    sdfcf_pkg::ST_SU_H3:
                    begin
                        mul_load  = 1'b1;
                        mul_a     = sdfcf_pkg::MUL_W'(prod_f[H_W-1:0]);
                        mul_b     = k_ext;
                        step_next = sdfcf_pkg::ST_SU_X;
                    end
                    sdfcf_pkg::ST_SU_X:
                    begin
                        // divide by six as halving then divide by three
                        mul_load  = 1'b1;
                        mul_a     = sdfcf_pkg::MUL_W'(prod_f[sdfcf_pkg::K_W-1:1]);
                        mul_b     = sdfcf_pkg::DIV3_MULT;
                        step_next = sdfcf_pkg::ST_SU_DIV;
                    end
                    sdfcf_pkg::ST_SU_DIV:
                    begin
                        res_next   = mnmx_d - term;
                        state_next = sdfcf_pkg::S_WRITE;
                    end
                    sdfcf_pkg::ST_SI_H:
                    begin
                        h_next    = hs_clip;
                        mul_load  = 1'b1;
                        mul_a     = u_reg;
                        mul_b     = sdfcf_pkg::MUL_W'(hs_clip);
                        step_next = sdfcf_pkg::ST_SI_UH;
                    end
                    sdfcf_pkg::ST_SI_UH:
                    begin
                        res_next  = sdfcf_pkg::D_W'(acc_reg)
                                  + $signed(prod_f[sdfcf_pkg::D_W-1:0]);
                        mul_load  = 1'b1;
                        mul_a     = sdfcf_pkg::MUL_W'(h_reg);
                        mul_b     = sdfcf_pkg::MUL_W'(ONE_H - h_reg);
                        step_next = sdfcf_pkg::ST_SI_G;
                    end
                    sdfcf_pkg::ST_SI_G:
                    begin
                        mul_load  = 1'b1;
                        mul_a     = k_ext;
                        mul_b     = sdfcf_pkg::MUL_W'(prod_f[H_W-1:0]);
                        step_next = sdfcf_pkg::ST_SI_KG;
                    end
                    sdfcf_pkg::ST_SI_KG:
                    begin
                        res_next   = res_reg + $signed(prod_f[sdfcf_pkg::D_W-1:0]);
                        state_next = sdfcf_pkg::S_WRITE;
                    end
                    sdfcf_pkg::ST_CH:
                    begin
                        if (is_union)
                            res_next = (cand < mnmx_d) ? cand : mnmx_d;
                        else
                            res_next = (cand > mnmx_d) ? cand : mnmx_d;
                        state_next = sdfcf_pkg::S_WRITE;
                    end
                    default:
                    begin
                        state_next = sdfcf_pkg::S_IDLE;
                    end
                endcase
            end

            sdfcf_pkg::S_WRITE:
            begin
                if (res_reg > sdfcf_pkg::ACC_MAX)
                begin
                    acc_next      = sdfcf_pkg::ACC_MAX[sdfcf_pkg::DIST_W-1:0];
                    sat_seen_next = 1'b1;
                end
                else if (res_reg < sdfcf_pkg::ACC_MIN)
                begin
                    acc_next      = sdfcf_pkg::ACC_MIN[sdfcf_pkg::DIST_W-1:0];
                    sat_seen_next = 1'b1;
                end
                else
                begin
                    acc_next = res_reg[sdfcf_pkg::DIST_W-1:0];
                end
                state_next = last_reg ? sdfcf_pkg::S_EMIT : sdfcf_pkg::S_IDLE;
            end

            sdfcf_pkg::S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load      = 1'b1;
                    run_open_next = 1'b0;
                    state_next    = sdfcf_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sdfcf_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            combine_mode_reg <= sdfcf_pkg::MODE_UNION;
            blend_width_reg  <= sdfcf_pkg::BLEND_RESET;
            blend_recip_reg  <= sdfcf_pkg::BLEND_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sdfcf_pkg::REG_COMBINE_MODE: combine_mode_reg <= cfg_data[sdfcf_pkg::MODE_W-1:0];
                sdfcf_pkg::REG_BLEND_WIDTH:  blend_width_reg  <= cfg_data[sdfcf_pkg::K_W-1:0];
                sdfcf_pkg::REG_BLEND_RECIP:  blend_recip_reg  <= cfg_data[sdfcf_pkg::K_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sdfcf_pkg::S_IDLE;
            step_reg      <= sdfcf_pkg::ST_CH;
            run_open_reg  <= 1'b0;
            sat_seen_reg  <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            run_open_reg  <= run_open_next;
            sat_seen_reg  <= sat_seen_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        last_reg <= last_next;
        u_reg    <= u_next;
        mnmx_reg <= mnmx_next;
        h_reg    <= h_next;
        res_reg  <= res_next;
        if (out_load)
        begin
            combined_reg  <= acc_reg;
            saturated_reg <= sat_seen_reg;
        end
    end

    assign in_stall          = (state_reg != sdfcf_pkg::S_IDLE);
    assign out_valid         = out_valid_reg;
    assign combined_distance = combined_reg;
    assign saturated         = saturated_reg;

    // a new result only appears as the run closes
    a_emit_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> !run_open_reg)
        else $error("result issued while run still open");

    // the seed never goes through the combine path
    a_prep_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == sdfcf_pkg::S_PREP |-> run_open_reg)
        else $error("combine started without a seeded run");

    // a clipped step is remembered
    a_clip_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdfcf_pkg::S_WRITE
            && (res_reg > sdfcf_pkg::ACC_MAX || res_reg < sdfcf_pkg::ACC_MIN))
        |=> sat_seen_reg)
        else $error("clipped step not flagged");

    // blend weight stays within [0, one]
    a_h_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sdfcf_pkg::S_STEP
            && (step_reg == sdfcf_pkg::ST_SU_H2 || step_reg == sdfcf_pkg::ST_SI_UH))
        |-> h_reg <= ONE_H)
        else $error("blend weight out of range");

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sdf combine fold unit: runs of child distances
// go in under random gaps and output stalls, a local fixed-point model of the
// fold predicts each run's folded distance and clip flag, and every result
// is checked in order against it
// ----------------------------------------------------------------------------

module tb_top;

    import sdfcf_pkg::*;

    localparam int     FRAC        = 16;
    localparam longint ONE         = longint'(1) << FRAC;
    localparam int     STALL_LIMIT = 2000;
    localparam int     SETTLE      = 20;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;
    localparam logic [MODE_W-1:0]    MODE_SPARE = 4'd15;

    typedef struct {
        logic signed [DIST_W-1:0] fold_value;
        logic                     clipped;
    } fold_result_t;

    logic                         clk            = 1'b0;
    logic                         rst_n          = 1'b0;
    logic                         cfg_write      = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index      = '0;
    logic [CFG_DATA_W-1:0]        cfg_data       = '0;
    logic                         in_valid       = 1'b0;
    logic                         in_stall;
    logic signed [DIST_W-1:0]     child_distance = '0;
    logic                         last_child     = 1'b0;
    logic                         out_valid;
    logic                         out_stall      = 1'b0;
    logic signed [DIST_W-1:0]     combined_distance;
    logic                         saturated;

    // fold model state and its copy of the registers
    logic [MODE_W-1:0] mode_q      = MODE_UNION;
    longint            width_q     = 65536;
    longint            recip_q     = 65536;
    longint            fold_acc    = 0;
    bit                run_active  = 1'b0;
    bit                run_clipped = 1'b0;

    fold_result_t expected_folds[$];
    int           mismatch_count = 0;
    int           quiet_cycles   = 0;
    bit           idle_on        = 1'b1;

    sdf_csg_combine_fold_unit uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .child_distance    (child_distance),
        .last_child        (last_child),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .combined_distance (combined_distance),
        .saturated         (saturated)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint lmin(longint x, longint y);
        return (x < y) ? x : y;
    endfunction

    function automatic longint lmax(longint x, longint y);
        return (x > y) ? x : y;
    endfunction

    function automatic longint chamfer_line(longint s);
        return (s * longint'(SQRT_HALF_Q30)) >>> CHAMFER_SHIFT;
    endfunction

    function automatic longint blend_union(longint a, longint b);
        longint d;
        longint h;
        longint h3;
        d = (a > b) ? a - b : b - a;
        h = 0;
        if (d < width_q)
        begin
            h = ((width_q - d) * recip_q) >>> FRAC;
            if (h > ONE)
                h = ONE;
        end
        h3 = ((((h * h) >>> FRAC) * h) >>> FRAC);
        return lmin(a, b) - (((h3 * width_q) >>> FRAC) / 6);
    endfunction

    function automatic longint blend_inter(longint a, longint b);
        longint u;
        longint uc;
        longint h;
        longint g;
        u = a - b;
        if (width_q == 0)
            h = (u > 0) ? ONE : ((u < 0) ? 0 : ONE / 2);
        else
        begin
            uc = (u > width_q) ? width_q : ((u < -width_q) ? -width_q : u);
            h = ONE / 2 + ((uc * recip_q) >>> (FRAC + 1));
            if (h < 0)
                h = 0;
            if (h > ONE)
                h = ONE;
        end
        g = (h * (ONE - h)) >>> FRAC;
        return b + ((u * h) >>> FRAC) + ((width_q * g) >>> FRAC);
    endfunction

    function automatic longint combine_pair(longint a, longint b);
        case (mode_q)
            MODE_SMOOTH_UNION:  return blend_union(a, b);
            MODE_CHAMFER_UNION: return lmin(lmin(a, b), chamfer_line(a - width_q + b));
            MODE_INTER:         return lmax(a, b);
            MODE_SMOOTH_INTER:  return blend_inter(a, b);
            MODE_CHAMFER_INTER: return lmax(lmax(a, b), chamfer_line(a + width_q + b));
            MODE_DIFF:          return lmax(-a, b);
            MODE_SMOOTH_DIFF:   return blend_inter(-a, b);
            MODE_CHAMFER_DIFF:  return lmax(lmax(-a, b), chamfer_line(-a + width_q + b));
            default:            return lmin(a, b);
        endcase
    endfunction

    task automatic predict_fold(input logic signed [DIST_W-1:0] child_val, input logic last);
        longint       a;
        longint       v;
        fold_result_t r;
        a = child_val;
        if (!run_active)
        begin
            fold_acc    = a;
            run_clipped = 1'b0;
            run_active  = 1'b1;
        end
        else
        begin
            v = combine_pair(a, fold_acc);
            if (v > ACC_MAX)
            begin
                v = ACC_MAX;
                run_clipped = 1'b1;
            end
            else if (v < ACC_MIN)
            begin
                v = ACC_MIN;
                run_clipped = 1'b1;
            end
            fold_acc = v;
        end
        if (last)
        begin
            r.fold_value = fold_acc[DIST_W-1:0];
            r.clipped    = run_clipped;
            expected_folds.push_back(r);
            run_active = 1'b0;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_COMBINE_MODE: mode_q  = data[MODE_W-1:0];
            REG_BLEND_WIDTH:  width_q = longint'(data[K_W-1:0]);
            REG_BLEND_RECIP:  recip_q = longint'(data[K_W-1:0]);
            default:          ;
        endcase
    endtask

    task automatic send_child(input logic signed [DIST_W-1:0] child_val, input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        child_distance <= child_val;
        last_child     <= last;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_fold(child_val, last);
    endtask

    task automatic hold_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_results();
        hold_input();
        while (expected_folds.size() != 0)
            @(posedge clk);
    endtask

    // all results in and the block given time to finish any open work
    task automatic drain();
        wait_results();
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic pair_run(input logic [MODE_W-1:0] mode, input logic [K_W-1:0] k,
                            input logic [K_W-1:0] r, input logic signed [DIST_W-1:0] b,
                            input logic signed [DIST_W-1:0] a);
        drain();
        write_reg(REG_COMBINE_MODE, CFG_DATA_W'(mode));
        write_reg(REG_BLEND_WIDTH, k);
        write_reg(REG_BLEND_RECIP, r);
        send_child(b, 1'b0);
        send_child(a, 1'b1);
    endtask

    task automatic random_setup();
        logic [MODE_W-1:0]     mode;
        logic [K_W-1:0]        k;
        logic [K_W-1:0]        r;
        logic [CFG_DATA_W-1:0] mode_word;
        longint                q;
        if ($urandom_range(0, 7) == 0)
            mode = MODE_W'($urandom_range(9, 15));
        else
            mode = MODE_W'($urandom_range(0, 8));
        mode_word = CFG_DATA_W'(mode);
        if ($urandom_range(0, 1) == 1)
            mode_word[CFG_DATA_W-1:MODE_W] = (CFG_DATA_W - MODE_W)'($urandom);
        case ($urandom_range(0, 9))
            0:       k = '0;
            1:       k = K_W'(1);
            2:       k = '1;
            3:       k = K_W'($urandom);
            default: k = K_W'($urandom_range(256, 32'h80000));
        endcase
        if (k == 0 || $urandom_range(0, 3) == 0)
            r = K_W'($urandom);
        else
        begin
            q = (ONE * ONE) / longint'(k);
            r = (q > ACC_MAX) ? '1 : K_W'(q);
        end
        drain();
        write_reg(REG_COMBINE_MODE, mode_word);
        write_reg(REG_BLEND_WIDTH, k);
        write_reg(REG_BLEND_RECIP, r);
    endtask

    // mostly values near the running fold or a random centre, some extremes and wild values
    function automatic logic signed [DIST_W-1:0] pick_distance();
        longint centre;
        longint spread;
        longint v;
        spread = (width_q > 16) ? width_q : 16;
        if (spread > (longint'(1) << 30))
            spread = longint'(1) << 30;
        centre = run_active ? fold_acc
                            : (longint'($signed($urandom)) >>> $urandom_range(4, 24));
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       v = ACC_MAX;
                    1:       v = ACC_MIN;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
            1, 2:    v = $signed($urandom);
            default: v = centre + longint'($urandom_range(0, 2 * spread)) - spread;
        endcase
        if (v > ACC_MAX)
            v = ACC_MAX;
        if (v < ACC_MIN)
            v = ACC_MIN;
        return v[DIST_W-1:0];
    endfunction

    task automatic random_runs(input int item_target, input bit pause_between);
        int sent;
        int len;
        sent = 0;
        random_setup();
        while (sent < item_target)
        begin
            if ($urandom_range(0, 11) == 0)
                random_setup();
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4);
            for (int i = 0; i < len; i++)
                send_child(pick_distance(), i == len - 1);
            sent += len;
            if (pause_between && $urandom_range(0, 1) == 1)
                wait_results();
        end
    endtask

    task automatic test_directed_corners();
        idle_on = 1'b1;
        send_child(32'sh80000000, 1'b1);
        drain();
        write_reg(REG_SPARE, '1);
        send_child(32'sh7fffffff, 1'b0);
        send_child(32'sh80000000, 1'b1);
        pair_run(MODE_SMOOTH_UNION, 31'd65536, 31'd65536, 32'sd0, 32'sh8000);
        pair_run(MODE_SMOOTH_UNION, 31'd65536, '1, 32'sd0, 32'sh4000);
        pair_run(MODE_SMOOTH_UNION, '0, 31'd65536, 32'sd7, 32'sd9);
        pair_run(MODE_CHAMFER_UNION, '1, 31'd1, 32'sh80000000, 32'sh80000000);
        pair_run(MODE_INTER, 31'd1, 31'd1, -32'sd1, 32'sd1);
        pair_run(MODE_SMOOTH_INTER, 31'd65536, 31'd65536, 32'sh1000, 32'sh1000);
        pair_run(MODE_SMOOTH_INTER, '0, 31'd65536, 32'sd5, -32'sd5);
        pair_run(MODE_CHAMFER_INTER, '1, '1, 32'sh7fffffff, 32'sh7fffffff);
        pair_run(MODE_DIFF, 31'd65536, 31'd65536, 32'sd0, 32'sh80000000);
        pair_run(MODE_SMOOTH_DIFF, '0, '0, 32'sd0, 32'sd0);
        pair_run(MODE_CHAMFER_DIFF, 31'd32768, 31'd131072, 32'sd200, 32'sd100);
        pair_run(MODE_SPARE, 31'd65536, 31'd65536, -32'sd3, 32'sd3);
        send_child(32'sh7fffffff, 1'b1);
    endtask

    task automatic test_random_with_gaps();
        idle_on = 1'b1;
        random_runs(700, 1'b0);
    endtask

    task automatic test_streaming();
        idle_on = 1'b0;
        random_runs(400, 1'b0);
    endtask

    task automatic test_results_drained();
        idle_on = 1'b1;
        random_runs(300, 1'b1);
    endtask

    // output stall: a fresh random hold-off before each result while gaps are on
    initial
    begin : result_sink
        int n;
        forever
        begin
            n = idle_on ? $urandom_range(0, 9) : 0;
            if (n > 0)
            begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(out_valid === 1'b1 && out_stall === 1'b0));
        end
    end

    always @(posedge clk)
    begin
        fold_result_t exp_r;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_folds.size() == 0)
            begin
                $display("%0t unexpected item: combined_distance %0d saturated %0b",
                         $time, combined_distance, saturated);
                mismatch_count++;
            end
            else
            begin
                exp_r = expected_folds.pop_front();
                if (combined_distance !== exp_r.fold_value)
                begin
                    $display("%0t combined_distance expected %0d actual %0d",
                             $time, exp_r.fold_value, combined_distance);
                    mismatch_count++;
                end
                if (saturated !== exp_r.clipped)
                begin
                    $display("%0t saturated expected %0b actual %0b",
                             $time, exp_r.clipped, saturated);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t timeout after %0d cycles with no item moving", $time, quiet_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        test_directed_corners();
        test_random_with_gaps();
        test_streaming();
        test_results_drained();
        drain();
        if (mismatch_count == 0 && expected_folds.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
